FILE: rtl/keyed_record_table_unit_defines.svh
// ----------------------------------------------------------------------------
// keyed_record_table_unit_defines
// assertion macros used by the record table controller
// ----------------------------------------------------------------------------
`ifndef KEYED_RECORD_TABLE_UNIT_DEFINES_SVH
`define KEYED_RECORD_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, held off while reset is asserted
`define KRT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("krt assertion failed");

// next-cycle implication, held off while reset is asserted
`define KRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("krt assertion failed");

`endif

FILE: rtl/krt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_pkg
// shared widths, command and status codes, result type and saturating add
// ----------------------------------------------------------------------------
package krt_pkg;

    localparam int CmdW       = 3;
    localparam int KeyW       = 24;
    localparam int ValW       = 32;
    localparam int StatusW    = 3;
    localparam int SlotW      = 6;
    localparam int MaxResults = 64;
    localparam int RecW       = KeyW + 2 * ValW;

    typedef enum logic [CmdW-1:0] {
        CMD_INSERT    = 3'd0,
        CMD_LOOKUP    = 3'd1,
        CMD_ADJ_QTY   = 3'd2,
        CMD_ADJ_PRICE = 3'd3,
        CMD_LIST      = 3'd4
    } cmd_t;

    typedef enum logic [StatusW-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_DUP       = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef struct packed {
        logic [StatusW-1:0]    status;
        logic [SlotW-1:0]      slot;
        logic [KeyW-1:0]       found_key;
        logic signed [ValW-1:0] quantity;
        logic signed [ValW-1:0] price;
        logic                  last;
    } result_t;

    function automatic logic signed [ValW-1:0] sat_add(
        input logic signed [ValW-1:0] a,
        input logic signed [ValW-1:0] b
    );
        logic signed [ValW:0] s;
        logic signed [ValW-1:0] r;
        s = {a[ValW-1], a} + {b[ValW-1], b};
        if (s[ValW] != s[ValW-1])
        begin
            r = s[ValW] ? {1'b1, {(ValW-1){1'b0}}} : {1'b0, {(ValW-1){1'b1}}};
        end
        else
        begin
            r = s[ValW-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/krt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_if
// request and response channels of the record table, valid/ready per beat
// ----------------------------------------------------------------------------
interface krt_req_if;
    import krt_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CmdW-1:0]        cmd;
    logic [KeyW-1:0]        part_key;
    logic signed [ValW-1:0] initial_quantity;
    logic signed [ValW-1:0] initial_price;
    logic signed [ValW-1:0] delta;

    modport source (
        output valid, cmd, part_key, initial_quantity, initial_price, delta,
        input  ready
    );
    modport sink (
        input  valid, cmd, part_key, initial_quantity, initial_price, delta,
        output ready
    );
endinterface

interface krt_rsp_if;
    import krt_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [StatusW-1:0]     status;
    logic [SlotW-1:0]       slot;
    logic [KeyW-1:0]        found_key;
    logic signed [ValW-1:0] quantity;
    logic signed [ValW-1:0] price;
    logic                   last;

    modport source (
        output valid, status, slot, found_key, quantity, price, last,
        input  ready
    );
    modport sink (
        input  valid, status, slot, found_key, quantity, price, last,
        output ready
    );
endinterface

FILE: rtl/krt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module krt_ram #(
    parameter int WIDTH = 88,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/krt_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_out_stage
// response register, holds one beat so the controller can move on
// ----------------------------------------------------------------------------
module krt_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_load,
    input  krt_pkg::result_t  res,
    output logic              out_free,
    krt_rsp_if.source         rsp
);
    import krt_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign out_free = !valid_reg || rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            data_reg <= res;
        end
    end

    assign rsp.valid     = valid_reg;
    assign rsp.status    = data_reg.status;
    assign rsp.slot      = data_reg.slot;
    assign rsp.found_key = data_reg.found_key;
    assign rsp.quantity  = data_reg.quantity;
    assign rsp.price     = data_reg.price;
    assign rsp.last      = data_reg.last;

endmodule

FILE: rtl/krt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_ctrl
// command sequencer: key scan over the record ram, insert, adjust, list
// ----------------------------------------------------------------------------
`include "keyed_record_table_unit_defines.svh"

module krt_ctrl #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    krt_req_if.sink                           req,
    output logic                              ram_wr_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]    ram_wr_addr,
    output logic [krt_pkg::RecW-1:0]          ram_wr_data,
    output logic                              ram_rd_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]    ram_rd_addr,
    input  logic [krt_pkg::RecW-1:0]          ram_rd_data,
    input  logic                              out_free,
    output logic                              res_load,
    output krt_pkg::result_t                  res
);
    import krt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int LW = (CW > 7) ? CW : 7;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_UPD  = 6'b000100,
        S_EMIT = 6'b001000,
        S_LRD  = 6'b010000,
        S_LOUT = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          ptr_reg, ptr_next;
    logic                   pend_reg, pend_next;
    logic [AW-1:0]          pend_idx_reg, pend_idx_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [KeyW-1:0]        key_reg, key_next;
    logic signed [ValW-1:0] qty_in_reg, qty_in_next;
    logic signed [ValW-1:0] price_in_reg, price_in_next;
    logic signed [ValW-1:0] delta_reg, delta_next;
    status_t                hold_status_reg, hold_status_next;
    logic [AW-1:0]          hold_idx_reg, hold_idx_next;
    logic [KeyW-1:0]        hold_key_reg, hold_key_next;
    logic signed [ValW-1:0] hold_qty_reg, hold_qty_next;
    logic signed [ValW-1:0] hold_price_reg, hold_price_next;

    logic [KeyW-1:0]        rd_key;
    logic signed [ValW-1:0] rd_qty;
    logic signed [ValW-1:0] rd_price;
    logic                   match;
    logic                   scan_more;
    logic                   scan_rd;
    logic [LW-1:0]          list_end;
    logic                   list_last;
    logic signed [ValW-1:0] upd_val;
    logic signed [ValW-1:0] upd_qty;
    logic signed [ValW-1:0] upd_price;

    assign rd_key   = ram_rd_data[RecW-1 -: KeyW];
    assign rd_qty   = ram_rd_data[2*ValW-1 -: ValW];
    assign rd_price = ram_rd_data[ValW-1:0];

    assign scan_more = ptr_reg < count_reg;
    assign match     = (state_reg == S_SCAN) && pend_reg && (rd_key == key_reg);
    assign scan_rd   = (state_reg == S_SCAN) && scan_more && !match;

    // list stops at the table fill or at the result cap, whichever is lower
    assign list_end  = (LW'(count_reg) > LW'(MaxResults)) ? LW'(MaxResults)
                                                           : LW'(count_reg);
    assign list_last = (LW'(ptr_reg) + LW'(1)) == list_end;

    assign upd_val   = sat_add((cmd_reg == CMD_ADJ_QTY) ? hold_qty_reg : hold_price_reg,
                               delta_reg);
    assign upd_qty   = (cmd_reg == CMD_ADJ_QTY) ? upd_val : hold_qty_reg;
    assign upd_price = (cmd_reg == CMD_ADJ_QTY) ? hold_price_reg : upd_val;

    assign req.ready   = (state_reg == S_IDLE);
    assign ram_rd_en   = scan_rd || (state_reg == S_LRD);
    assign ram_rd_addr = ptr_reg[AW-1:0];

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        ptr_next         = ptr_reg;
        pend_next        = pend_reg;
        pend_idx_next    = pend_idx_reg;
        cmd_next         = cmd_reg;
        key_next         = key_reg;
        qty_in_next      = qty_in_reg;
        price_in_next    = price_in_reg;
        delta_next       = delta_reg;
        hold_status_next = hold_status_reg;
        hold_idx_next    = hold_idx_reg;
        hold_key_next    = hold_key_reg;
        hold_qty_next    = hold_qty_reg;
        hold_price_next  = hold_price_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = hold_idx_reg;
        ram_wr_data      = {hold_key_reg, upd_qty, upd_price};
        res_load         = 1'b0;
        res.status       = hold_status_reg;
        res.slot         = SlotW'(hold_idx_reg);
        res.found_key    = hold_key_reg;
        res.quantity     = hold_qty_reg;
        res.price        = hold_price_reg;
        res.last         = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next      = cmd_t'(req.cmd);
                    key_next      = req.part_key;
                    qty_in_next   = req.initial_quantity;
                    price_in_next = req.initial_price;
                    delta_next    = req.delta;
                    ptr_next      = '0;
                    pend_next     = 1'b0;
                    hold_idx_next   = '0;
                    hold_key_next   = '0;
                    hold_qty_next   = '0;
                    hold_price_next = '0;
                    case (cmd_t'(req.cmd))
                        CMD_INSERT:
                        begin
                            if (count_reg == CW'(TABLE_DEPTH))
                            begin
                                hold_status_next = ST_FULL;
                                state_next       = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        CMD_LOOKUP, CMD_ADJ_QTY, CMD_ADJ_PRICE:
                        begin
                            state_next = S_SCAN;
                        end
                        CMD_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                hold_status_next = ST_EMPTY;
                                state_next       = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_LRD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // one read issued per cycle, compare lags by the ram latency
                pend_next     = scan_rd;
                pend_idx_next = ptr_reg[AW-1:0];
                if (scan_rd)
                begin
                    ptr_next = ptr_reg + CW'(1);
                end
                if (match)
                begin
                    hold_idx_next    = pend_idx_reg;
                    hold_key_next    = rd_key;
                    hold_qty_next    = rd_qty;
                    hold_price_next  = rd_price;
                    hold_status_next = (cmd_reg == CMD_INSERT) ? ST_DUP : ST_OK;
                    if (cmd_reg inside {CMD_ADJ_QTY, CMD_ADJ_PRICE})
                    begin
                        state_next = S_UPD;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
                else if (!pend_reg && !scan_more)
                begin
                    if (cmd_reg == CMD_INSERT)
                    begin
                        ram_wr_en        = 1'b1;
                        ram_wr_addr      = count_reg[AW-1:0];
                        ram_wr_data      = {key_reg, qty_in_reg, price_in_reg};
                        hold_status_next = ST_OK;
                        hold_idx_next    = count_reg[AW-1:0];
                        hold_key_next    = key_reg;
                        hold_qty_next    = qty_in_reg;
                        hold_price_next  = price_in_reg;
                        count_next       = count_reg + CW'(1);
                    end
                    else
                    begin
                        hold_status_next = ST_NOT_FOUND;
                    end
                    state_next = S_EMIT;
                end
            end

            S_UPD:
            begin
                ram_wr_en       = 1'b1;
                hold_qty_next   = upd_qty;
                hold_price_next = upd_price;
                state_next      = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_LRD:
            begin
                state_next = S_LOUT;
            end

            S_LOUT:
            begin
                // ram output holds while no new read is issued
                res.status    = ST_OK;
                res.slot      = SlotW'(ptr_reg[AW-1:0]);
                res.found_key = rd_key;
                res.quantity  = rd_qty;
                res.price     = rd_price;
                res.last      = list_last;
                if (out_free)
                begin
                    res_load = 1'b1;
                    if (list_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + CW'(1);
                        state_next = S_LRD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg    <= pend_idx_next;
        cmd_reg         <= cmd_next;
        key_reg         <= key_next;
        qty_in_reg      <= qty_in_next;
        price_in_reg    <= price_in_next;
        delta_reg       <= delta_next;
        hold_status_reg <= hold_status_next;
        hold_idx_reg    <= hold_idx_next;
        hold_key_reg    <= hold_key_next;
        hold_qty_reg    <= hold_qty_next;
        hold_price_reg  <= hold_price_next;
    end

    `KRT_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(TABLE_DEPTH))
    `KRT_ASSERT_IMPL(a_write_state, clk, rst_n, ram_wr_en,
        (state_reg == S_SCAN) || (state_reg == S_UPD))
    `KRT_ASSERT_NEXT(a_count_hold, clk, rst_n, state_reg != S_SCAN,
        count_reg == $past(count_reg))
    `KRT_ASSERT_IMPL(a_pend_in_fill, clk, rst_n, (state_reg == S_SCAN) && pend_reg,
        CW'(pend_idx_reg) < count_reg)
    `KRT_ASSERT_IMPL(a_load_free, clk, rst_n, res_load, out_free && !req.ready)

endmodule

FILE: rtl/keyed_record_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_record_table_unit
// keyed record table with linear key search, saturating adjust and listing
// ----------------------------------------------------------------------------
// Records (24-bit key, signed quantity, signed price) sit in one synchronous
// ram of TABLE_DEPTH rows and are appended in arrival order. Insert, lookup
// and both adjust commands scan the filled rows one read per cycle up to the
// first hit, and an adjust then writes the saturated value back. List reads
// the filled rows up to the result cap and emits one beat per row. The
// response register lets the next request be taken while the last beat still
// waits. Unused command codes are dropped with no response.
module keyed_record_table_unit #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    krt_req_if.sink   req,
    krt_rsp_if.source rsp
);
    import krt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    logic            ram_wr_en;
    logic [AW-1:0]   ram_wr_addr;
    logic [RecW-1:0] ram_wr_data;
    logic            ram_rd_en;
    logic [AW-1:0]   ram_rd_addr;
    logic [RecW-1:0] ram_rd_data;
    logic            out_free;
    logic            res_load;
    result_t         res;

    krt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .out_free    (out_free),
        .res_load    (res_load),
        .res         (res)
    );

    krt_ram #(
        .WIDTH (RecW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    krt_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_load (res_load),
        .res      (res),
        .out_free (out_free),
        .rsp      (rsp)
    );

endmodule

FILE: tb/keyed_record_table_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_record_table_unit_test
// self-checking bench for the keyed record table: a scoreboard keeps its own
// copy of the table and predicts every response beat, while tasks drive
// directed corner cases, random traffic on live keys and a full-table phase,
// with random sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module keyed_record_table_unit_test;
    import krt_pkg::*;

    localparam int TableDepth  = 64;
    localparam int RandomItems = 40;
    localparam int IdleLimit   = 2000;
    localparam int DrainCycles = 80;
    localparam int ReportLimit = 10;
    localparam logic signed [ValW-1:0] ValMax = 32'sh7fffffff;
    localparam logic signed [ValW-1:0] ValMin = 32'sh80000000;
    localparam logic [KeyW-1:0] KeyMax = '1;

    class record_scoreboard;
        logic [KeyW-1:0]        key_at[TableDepth];
        logic signed [ValW-1:0] qty_at[TableDepth];
        logic signed [ValW-1:0] price_at[TableDepth];
        int                     filled;
        result_t                pending[$];
        int                     mismatches;

        function new();
            filled = 0;
            mismatches = 0;
        endfunction

        function int find_slot(logic [KeyW-1:0] key);
            for (int i = 0; i < filled; i++)
            begin
                if (key_at[i] == key)
                begin
                    return i;
                end
            end
            return -1;
        endfunction

        function logic signed [ValW-1:0] clamp_add(logic signed [ValW-1:0] a,
                                                   logic signed [ValW-1:0] b);
            longint s;
            s = longint'(a) + longint'(b);
            if (s > longint'(ValMax))
            begin
                return ValMax;
            end
            if (s < longint'(ValMin))
            begin
                return ValMin;
            end
            return s[ValW-1:0];
        endfunction

        function void expect_entry(status_t st, int idx, logic last);
            result_t r;
            r = '0;
            r.status = st;
            r.last = last;
            if (idx >= 0)
            begin
                r.slot = idx[SlotW-1:0];
                r.found_key = key_at[idx];
                r.quantity = qty_at[idx];
                r.price = price_at[idx];
            end
            pending.push_back(r);
        endfunction

        function void note_request(logic [CmdW-1:0] op, logic [KeyW-1:0] key,
                                   logic signed [ValW-1:0] qty,
                                   logic signed [ValW-1:0] price,
                                   logic signed [ValW-1:0] delta);
            int idx;
            int n;
            case (op)
                CMD_INSERT:
                begin
                    // full is reported before any duplicate check
                    if (filled >= TableDepth)
                    begin
                        expect_entry(ST_FULL, -1, 1'b1);
                    end
                    else
                    begin
                        idx = find_slot(key);
                        if (idx >= 0)
                        begin
                            expect_entry(ST_DUP, idx, 1'b1);
                        end
                        else
                        begin
                            key_at[filled] = key;
                            qty_at[filled] = qty;
                            price_at[filled] = price;
                            filled++;
                            expect_entry(ST_OK, filled - 1, 1'b1);
                        end
                    end
                end
                CMD_LOOKUP, CMD_ADJ_QTY, CMD_ADJ_PRICE:
                begin
                    idx = find_slot(key);
                    if (idx < 0)
                    begin
                        expect_entry(ST_NOT_FOUND, -1, 1'b1);
                    end
                    else
                    begin
                        if (op == CMD_ADJ_QTY)
                        begin
                            qty_at[idx] = clamp_add(qty_at[idx], delta);
                        end
                        else if (op == CMD_ADJ_PRICE)
                        begin
                            price_at[idx] = clamp_add(price_at[idx], delta);
                        end
                        expect_entry(ST_OK, idx, 1'b1);
                    end
                end
                CMD_LIST:
                begin
                    if (filled == 0)
                    begin
                        expect_entry(ST_EMPTY, -1, 1'b1);
                    end
                    else
                    begin
                        n = (filled > MaxResults) ? MaxResults : filled;
                        for (int i = 0; i < n; i++)
                        begin
                            expect_entry(ST_OK, i, i == n - 1);
                        end
                    end
                end
                default:
                begin
                    // unused codes are dropped without a beat
                end
            endcase
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= ReportLimit)
                begin
                    $display("unexpected beat: status %0d slot %0d key %h qty %0d price %0d last %b",
                             got.status, got.slot, got.found_key, got.quantity, got.price,
                             got.last);
                end
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status || got.slot !== want.slot
                || got.found_key !== want.found_key || got.quantity !== want.quantity
                || got.price !== want.price || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= ReportLimit)
                begin
                    $display("mismatch expected: status %0d slot %0d key %h qty %0d price %0d last %b",
                             want.status, want.slot, want.found_key, want.quantity,
                             want.price, want.last);
                    $display("         actual:   status %0d slot %0d key %h qty %0d price %0d last %b",
                             got.status, got.slot, got.found_key, got.quantity, got.price,
                             got.last);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    krt_req_if req_ch();
    krt_rsp_if rsp_ch();

    keyed_record_table_unit #(
        .TABLE_DEPTH(TableDepth)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    record_scoreboard sb;
    int burst_left;
    int idle_cycles;
    int stall_mode;
    int stall_run_left;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: runs of always-ready, light stalls and heavy stalls
    always @(negedge clk)
    begin
        if (stall_run_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_run_left = $urandom_range(16, 64);
        end
        else
        begin
            stall_run_left--;
        end
        case (stall_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                sb.check_result({rsp_ch.status, rsp_ch.slot, rsp_ch.found_key,
                                 rsp_ch.quantity, rsp_ch.price, rsp_ch.last});
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IdleLimit)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [CmdW-1:0] op, input logic [KeyW-1:0] key,
                                input logic signed [ValW-1:0] qty,
                                input logic signed [ValW-1:0] price,
                                input logic signed [ValW-1:0] delta);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 8);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd <= op;
        req_ch.part_key <= key;
        req_ch.initial_quantity <= qty;
        req_ch.initial_price <= price;
        req_ch.delta <= delta;
        burst_left--;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(op, key, qty, price, delta);
    endtask

    // mostly keys already in the table so lookups and adjusts hit
    function automatic logic [KeyW-1:0] pick_key();
        logic [KeyW-1:0] k;
        if (sb.filled != 0 && $urandom_range(0, 3) != 0)
        begin
            k = sb.key_at[$urandom_range(0, sb.filled - 1)];
        end
        else
        begin
            k = KeyW'($urandom);
        end
        return k;
    endfunction

    function automatic logic signed [ValW-1:0] pick_value();
        logic signed [ValW-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = ValMax;
            1:       v = ValMin;
            2, 3:    v = $urandom_range(0, 200) - 100;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic run_directed();
        send_request(CMD_LIST, '0, '0, '0, '0);
        send_request(CMD_LOOKUP, '0, '0, '0, '0);
        send_request(CMD_ADJ_QTY, '0, '0, '0, 32'sd5);
        send_request(CMD_ADJ_PRICE, KeyMax, '0, '0, 32'sd5);
        for (int c = int'(CMD_LIST) + 1; c < (1 << CmdW); c++)
        begin
            send_request(c[CmdW-1:0], KeyMax, ValMax, ValMin, ValMax);
        end
        send_request(CMD_INSERT, '0, ValMax, ValMin, '0);
        send_request(CMD_INSERT, KeyMax, ValMin, ValMax, '0);
        send_request(CMD_INSERT, '0, 32'sd1, 32'sd2, '0);
        send_request(CMD_INSERT, 24'h123456, '0, -32'sd1, '0);
        send_request(CMD_LOOKUP, KeyMax, '0, '0, '0);
        // saturation at both ends on both values
        send_request(CMD_ADJ_QTY, '0, '0, '0, 32'sd1);
        send_request(CMD_ADJ_QTY, KeyMax, '0, '0, -32'sd1);
        send_request(CMD_ADJ_PRICE, '0, '0, '0, ValMin);
        send_request(CMD_ADJ_PRICE, KeyMax, '0, '0, ValMax);
        send_request(CMD_ADJ_QTY, 24'h123456, '0, '0, ValMax);
        send_request(CMD_ADJ_QTY, 24'h123456, '0, '0, ValMin);
        send_request(CMD_LOOKUP, 24'habcdef, '0, '0, '0);
        send_request(CMD_LIST, '0, '0, '0, '0);
    endtask

    task automatic run_random(input int count);
        int done_items;
        int pick;
        logic [CmdW-1:0] op;
        logic [KeyW-1:0] key;
        done_items = 0;
        while (done_items < count)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 7)
                op = CMD_INSERT;
            else if (pick < 11)
                op = CMD_LOOKUP;
            else if (pick < 14)
                op = CMD_ADJ_QTY;
            else if (pick < 17)
                op = CMD_ADJ_PRICE;
            else if (pick < 18)
                op = CMD_LIST;
            else
                op = CmdW'($urandom_range(int'(CMD_LIST) + 1, (1 << CmdW) - 1));
            if (op == CMD_INSERT && $urandom_range(0, 3) != 0)
                key = KeyW'($urandom);
            else
                key = pick_key();
            send_request(op, key, pick_value(), pick_value(), pick_value());
            if (op <= CMD_LIST)
            begin
                done_items++;
            end
        end
    endtask

    task automatic run_full_table();
        while (sb.filled < TableDepth)
        begin
            send_request(CMD_INSERT, KeyW'($urandom), pick_value(), pick_value(), '0);
        end
        send_request(CMD_INSERT, KeyW'($urandom), pick_value(), pick_value(), '0);
        // a present key on a full table still reports full
        send_request(CMD_INSERT, sb.key_at[0], '0, '0, '0);
        send_request(CMD_LOOKUP, sb.key_at[TableDepth - 1], '0, '0, '0);
        send_request(CMD_ADJ_PRICE, sb.key_at[TableDepth - 1], '0, '0, pick_value());
        send_request(CMD_LIST, '0, '0, '0, '0);
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.cmd = '0;
        req_ch.part_key = '0;
        req_ch.initial_quantity = '0;
        req_ch.initial_price = '0;
        req_ch.delta = '0;
        rsp_ch.ready = 1'b0;
        burst_left = 0;
        idle_cycles = 0;
        stall_mode = 0;
        stall_run_left = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        run_directed();
        run_random(RandomItems);
        run_full_table();
        run_random(12);
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
